/* rtl/core/mbcs_pkg.sv */
// ----------------------------------------------------------------------------
// mbcs_pkg
// Shared constants, codes and stage types of the masked count/sum aggregate.
// ----------------------------------------------------------------------------
package mbcs_pkg;

    // lane geometry
    localparam int LANES        = 8;
    localparam int FIELD_LANES  = 8;
    localparam int ACTIVE_LANES = (LANES > FIELD_LANES) ? FIELD_LANES : LANES;

    // field widths
    localparam int OP_W    = 2;
    localparam int KIND_W  = 2;
    localparam int MASK_W  = 8;
    localparam int VALUE_W = 32;
    localparam int ACC_W   = 64;

    // prefix sums of the lane contributions stay exact at this width
    localparam int PSUM_W = VALUE_W + $clog2(ACTIVE_LANES) + 1;
    // accumulator plus one prefix, one guard bit for the range check
    localparam int SUM_W  = ACC_W + 1;

    // operation codes of an input transaction
    typedef enum logic [OP_W-1:0] {
        OP_CHUNK  = 2'd0,
        OP_FINISH = 2'd1,
        OP_RESET  = 2'd2
    } op_t;

    // aggregate kinds; the unused code behaves like sum
    typedef enum logic [KIND_W-1:0] {
        KIND_COUNT_ALL     = 2'd0,
        KIND_COUNT_NONNULL = 2'd1,
        KIND_SUM           = 2'd2
    } kind_t;

    // one chunk after the lane merge, as held in the stage register
    typedef struct packed {
        logic [OP_W-1:0]                     op;
        logic [KIND_W-1:0]                   kind;
        logic                                any_active;
        logic [ACTIVE_LANES-1:0][PSUM_W-1:0] psum;
    } stage_t;

endpackage

/* rtl/core/mbcs_ifs.sv */
// ----------------------------------------------------------------------------
// mbcs_ifs
// Valid/ready channels of the aggregate: chunk input, result output, config.
// ----------------------------------------------------------------------------

// chunk input channel
interface mbcs_chunk_if;
    logic                                 valid;
    logic                                 ready;
    logic [mbcs_pkg::OP_W-1:0]            operation;
    logic [mbcs_pkg::MASK_W-1:0]          selected_mask;
    logic [mbcs_pkg::MASK_W-1:0]          null_mask;
    logic signed [mbcs_pkg::VALUE_W-1:0]  value_0;
    logic signed [mbcs_pkg::VALUE_W-1:0]  value_1;
    logic signed [mbcs_pkg::VALUE_W-1:0]  value_2;
    logic signed [mbcs_pkg::VALUE_W-1:0]  value_3;
    logic signed [mbcs_pkg::VALUE_W-1:0]  value_4;
    logic signed [mbcs_pkg::VALUE_W-1:0]  value_5;
    logic signed [mbcs_pkg::VALUE_W-1:0]  value_6;
    logic signed [mbcs_pkg::VALUE_W-1:0]  value_7;

    modport source (
        output valid, operation, selected_mask, null_mask,
               value_0, value_1, value_2, value_3, value_4, value_5, value_6, value_7,
        input  ready
    );
    modport sink (
        input  valid, operation, selected_mask, null_mask,
               value_0, value_1, value_2, value_3, value_4, value_5, value_6, value_7,
        output ready
    );
endinterface

// result output channel
interface mbcs_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [mbcs_pkg::ACC_W-1:0]  total;
    logic                               total_is_null;
    logic                               overflow;

    modport source (
        output valid, total, total_is_null, overflow,
        input  ready
    );
    modport sink (
        input  valid, total, total_is_null, overflow,
        output ready
    );
endinterface

// configuration write channel
interface mbcs_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [mbcs_pkg::KIND_W-1:0]   agg_kind;

    modport source (
        output valid, agg_kind,
        input  ready
    );
    modport sink (
        input  valid, agg_kind,
        output ready
    );
endinterface

/* rtl/core/mbcs_lane.sv */
// ----------------------------------------------------------------------------
// mbcs_lane
// One row lane: masks the row by selection and null bits and gives its
// contribution to the running total under the current aggregate kind.
// ----------------------------------------------------------------------------
module mbcs_lane (
    input  logic                                sel,
    input  logic                                nul,
    input  logic signed [mbcs_pkg::VALUE_W-1:0] value,
    input  logic [mbcs_pkg::KIND_W-1:0]         kind,
    output logic signed [mbcs_pkg::VALUE_W-1:0] contrib,
    output logic                                active
);

    logic counted;

    // a row counts when selected and not null
    assign counted = sel & ~nul;

    // contribution per kind
    always_comb
    begin
        unique case (kind)
            mbcs_pkg::KIND_COUNT_ALL:
            begin
                active  = sel;
                contrib = sel ? mbcs_pkg::VALUE_W'(1) : '0;
            end
            mbcs_pkg::KIND_COUNT_NONNULL:
            begin
                active  = counted;
                contrib = counted ? mbcs_pkg::VALUE_W'(1) : '0;
            end
            default:
            begin
                active  = counted;
                contrib = counted ? value : '0;
            end
        endcase
    end

endmodule

/* rtl/core/mbcs_merge.sv */
// ----------------------------------------------------------------------------
// mbcs_merge
// Merging stage: forms the lowest-lane-first prefix sums of the lane
// contributions and holds the merged chunk in the stage register.
// ----------------------------------------------------------------------------
module mbcs_merge (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic                                                load,
    input  logic                                                advance,
    input  logic [mbcs_pkg::OP_W-1:0]                           op,
    input  logic [mbcs_pkg::KIND_W-1:0]                         kind,
    input  logic [mbcs_pkg::ACTIVE_LANES-1:0][mbcs_pkg::VALUE_W-1:0] contrib,
    input  logic [mbcs_pkg::ACTIVE_LANES-1:0]                   active,
    output mbcs_pkg::stage_t                                    stage,
    output logic                                                stage_valid
);

    mbcs_pkg::stage_t stage_reg;
    mbcs_pkg::stage_t stage_next;
    logic             valid_reg;
    logic             valid_next;
    logic [mbcs_pkg::PSUM_W-1:0] run;

    // prefix chain over the lanes
    always_comb
    begin
        run = '0;
        stage_next.op         = op;
        stage_next.kind       = kind;
        stage_next.any_active = |active;
        for (int i = 0; i < mbcs_pkg::ACTIVE_LANES; i++)
        begin
            run = run + {{(mbcs_pkg::PSUM_W - mbcs_pkg::VALUE_W){contrib[i][mbcs_pkg::VALUE_W-1]}},
                         contrib[i]};
            stage_next.psum[i] = run;
        end
    end

    // stage occupancy
    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage       = stage_reg;
    assign stage_valid = valid_reg;

endmodule

/* rtl/core/mbcs_accum.sv */
// ----------------------------------------------------------------------------
// mbcs_accum
// Accumulator state: checks every prefix of a chunk against the signed
// 64-bit range, updates the total and flags, and holds the result register.
// ----------------------------------------------------------------------------
module mbcs_accum (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mbcs_pkg::stage_t                   stage,
    input  logic                               fire,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic signed [mbcs_pkg::ACC_W-1:0]  out_total,
    output logic                               out_total_is_null,
    output logic                               out_overflow,
    output logic                               out_hold
);

    logic [mbcs_pkg::ACC_W-1:0] acc_reg;
    logic [mbcs_pkg::ACC_W-1:0] acc_next;
    logic                       seen_reg;
    logic                       seen_next;
    logic                       emitted_reg;
    logic                       emitted_next;
    logic                       ovf_reg;
    logic                       ovf_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [mbcs_pkg::ACC_W-1:0] total_reg;
    logic [mbcs_pkg::ACC_W-1:0] total_next;
    logic                       is_null_reg;
    logic                       is_null_next;
    logic                       out_ovf_reg;
    logic                       out_ovf_next;
    logic                       emit;
    logic                       ovf_any;
    logic                       is_count;
    logic [mbcs_pkg::SUM_W-1:0] sums [mbcs_pkg::ACTIVE_LANES];

    // running total after each lane, one adder per lane
    always_comb
    begin
        ovf_any = 1'b0;
        for (int k = 0; k < mbcs_pkg::ACTIVE_LANES; k++)
        begin
            sums[k] = {acc_reg[mbcs_pkg::ACC_W-1], acc_reg}
                    + {{(mbcs_pkg::SUM_W - mbcs_pkg::PSUM_W){stage.psum[k][mbcs_pkg::PSUM_W-1]}},
                       stage.psum[k]};
            ovf_any = ovf_any | (sums[k][mbcs_pkg::SUM_W-1] ^ sums[k][mbcs_pkg::SUM_W-2]);
        end
    end

    assign is_count = (stage.kind == mbcs_pkg::KIND_COUNT_ALL)
                   || (stage.kind == mbcs_pkg::KIND_COUNT_NONNULL);

    // state update per transaction
    always_comb
    begin
        acc_next     = acc_reg;
        seen_next    = seen_reg;
        emitted_next = emitted_reg;
        ovf_next     = ovf_reg;
        emit         = 1'b0;
        total_next   = acc_reg;
        is_null_next = 1'b0;
        out_ovf_next = 1'b0;
        if (fire)
        begin
            unique case (stage.op)
                mbcs_pkg::OP_RESET:
                begin
                    acc_next     = '0;
                    seen_next    = 1'b0;
                    emitted_next = 1'b0;
                    ovf_next     = 1'b0;
                end
                mbcs_pkg::OP_CHUNK:
                begin
                    if (!emitted_reg && !ovf_reg)
                    begin
                        if (ovf_any)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            acc_next = sums[mbcs_pkg::ACTIVE_LANES-1][mbcs_pkg::ACC_W-1:0];
                        end
                        if ((stage.kind == mbcs_pkg::KIND_COUNT_ALL) || stage.any_active)
                        begin
                            seen_next = 1'b1;
                        end
                    end
                end
                mbcs_pkg::OP_FINISH:
                begin
                    if (!emitted_reg)
                    begin
                        emitted_next = 1'b1;
                        emit         = 1'b1;
                        if (ovf_reg)
                        begin
                            total_next   = '0;
                            out_ovf_next = 1'b1;
                        end
                        else if (!is_count && !seen_reg)
                        begin
                            total_next   = '0;
                            is_null_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // result register occupancy
    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            seen_reg      <= 1'b0;
            emitted_reg   <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            seen_reg      <= seen_next;
            emitted_reg   <= emitted_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            total_reg   <= total_next;
            is_null_reg <= is_null_next;
            out_ovf_reg <= out_ovf_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_total         = total_reg;
    assign out_total_is_null = is_null_reg;
    assign out_overflow      = out_ovf_reg;
    assign out_hold          = out_valid_reg & ~out_ready;

endmodule

/* rtl/core/masked_batch_count_sum_aggregate.sv */
// a finish transaction is held in the stage register, and its result then in the result register
// throughput: one chunk per cycle unless stalled; eight lanes and one prefix adder per lane
// the only stall is a finish meeting a result register that is still full
// reset (rst_n, async, active low) clears the kind, total, flags and pipeline
// ----------------------------------------------------------------------------
// masked_batch_count_sum_aggregate
// COUNT(*), COUNT(column) or SUM of int4 over masked row chunks into a
// signed 64-bit total with sticky overflow, emitted on the first finish after a reset.
// ----------------------------------------------------------------------------
module masked_batch_count_sum_aggregate (
    input  logic          clk,
    input  logic          rst_n,
    mbcs_chunk_if.sink    chunk,
    mbcs_cfg_if.sink      cfg,
    mbcs_result_if.source result
);

    logic [mbcs_pkg::KIND_W-1:0] kind_reg;
    logic signed [mbcs_pkg::VALUE_W-1:0] values [mbcs_pkg::FIELD_LANES];
    logic [mbcs_pkg::ACTIVE_LANES-1:0][mbcs_pkg::VALUE_W-1:0] contrib;
    logic [mbcs_pkg::ACTIVE_LANES-1:0] active;
    mbcs_pkg::stage_t stage;
    logic stage_valid;
    logic advance;
    logic load;
    logic hold;

    // configuration register, always ready
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= mbcs_pkg::KIND_COUNT_ALL;
        end
        else if (cfg.valid)
        begin
            kind_reg <= cfg.agg_kind;
        end
    end

    // lane values in lane order
    assign values[0] = chunk.value_0;
    assign values[1] = chunk.value_1;
    assign values[2] = chunk.value_2;
    assign values[3] = chunk.value_3;
    assign values[4] = chunk.value_4;
    assign values[5] = chunk.value_5;
    assign values[6] = chunk.value_6;
    assign values[7] = chunk.value_7;

    // row lanes
    for (genvar i = 0; i < mbcs_pkg::ACTIVE_LANES; i++)
    begin : g_lane
        mbcs_lane u_lane (
            .sel     (chunk.selected_mask[i]),
            .nul     (chunk.null_mask[i]),
            .value   (values[i]),
            .kind    (kind_reg),
            .contrib (contrib[i]),
            .active  (active[i])
        );
    end

    // flow control between input, stage register and result register
    assign advance     = stage_valid
                      && !((stage.op == mbcs_pkg::OP_FINISH) && hold);
    assign chunk.ready = !stage_valid || advance;
    assign load        = chunk.valid && chunk.ready;

    mbcs_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .advance     (advance),
        .op          (chunk.operation),
        .kind        (kind_reg),
        .contrib     (contrib),
        .active      (active),
        .stage       (stage),
        .stage_valid (stage_valid)
    );

    mbcs_accum u_accum (
        .clk               (clk),
        .rst_n             (rst_n),
        .stage             (stage),
        .fire              (advance),
        .out_ready         (result.ready),
        .out_valid         (result.valid),
        .out_total         (result.total),
        .out_total_is_null (result.total_is_null),
        .out_overflow      (result.overflow),
        .out_hold          (hold)
    );

endmodule

/* rtl/core/mbcs_checker.sv */
// ----------------------------------------------------------------------------
// mbcs_checker
// Port-level checks on the result channel of the aggregate, bound to the top.
// ----------------------------------------------------------------------------
module mbcs_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               res_valid,
    input logic                               res_ready,
    input logic signed [mbcs_pkg::ACC_W-1:0]  res_total,
    input logic                               res_total_is_null,
    input logic                               res_overflow
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_total) && $stable(res_total_is_null)
                                    && $stable(res_overflow))
        else $error("result payload changed while stalled");

    // an overflowed result reports zero and is not null
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_overflow |-> (res_total == '0) && !res_total_is_null)
        else $error("overflow result carries a total or null flag");

    // a null sum reports zero and no overflow
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_total_is_null |-> (res_total == '0) && !res_overflow)
        else $error("null result carries a total or overflow flag");

endmodule

bind masked_batch_count_sum_aggregate mbcs_checker u_mbcs_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .res_valid         (result.valid),
    .res_ready         (result.ready),
    .res_total         (result.total),
    .res_total_is_null (result.total_is_null),
    .res_overflow      (result.overflow)
);
